// File: rtl/dct_lowfreq_frame_change_detector_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the low-frequency DCT frame change detector
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DCT_LOWFREQ_FRAME_CHANGE_DETECTOR_TOP_ASSERT_SVH
`define DCT_LOWFREQ_FRAME_CHANGE_DETECTOR_TOP_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define DLFCD_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
	else $error(msg);
// expression must never be true outside reset
`define DLFCD_NEVER(lbl, clk_i, rst_ni, expr, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
	else $error(msg);
`else
`define DLFCD_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`define DLFCD_NEVER(lbl, clk_i, rst_ni, expr, msg)
`endif
`endif

// File: rtl/dlfcd_pkg.sv
// ----------------------------------------------------------------------------
// dlfcd_pkg
// Shared widths, reset values, register codes and control bundles.
// ----------------------------------------------------------------------------
package dlfcd_pkg;

	// sample store geometry
	localparam int MAX_BLOCKS = 16384;
	localparam int ADDR_W     = 14;
	localparam int FILL_W     = ADDR_W + 1;
	localparam int SPB        = 4;
	localparam int SAMP_W     = 16;
	localparam int ROW_W      = SPB * SAMP_W;

	// frame position and length (up to 4095 tiles times 6 blocks)
	localparam int POS_W = 15;
	localparam int LEN_W = 15;

	// arithmetic widths
	localparam int SUM_W      = 18;
	localparam int TOTAL_W    = 33;
	localparam int DIVIDEND_W = 44;
	localparam int CNT_W      = 6;
	localparam int SCORE_W    = 32;

	// score scale 2000 = 2048 - 32 - 16
	localparam int SCALE_SH_A = 11;
	localparam int SCALE_SH_B = 5;
	localparam int SCALE_SH_C = 4;

	// register widths
	localparam int NOISE_W = 18;
	localparam int DELTA_W = 32;
	localparam int TILES_W = 12;
	localparam int BPT_W   = 3;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register reset values and clamps
	localparam logic [NOISE_W-1:0] NOISE_RESET = 18'd10;
	localparam logic [DELTA_W-1:0] DELTA_RESET = 32'd400;
	localparam logic [TILES_W-1:0] TILES_RESET = 12'd1;
	localparam logic [BPT_W-1:0]   BPT_RESET   = 3'd3;
	localparam logic [BPT_W-1:0]   BPT_MIN     = 3'd3;
	localparam logic [BPT_W-1:0]   BPT_MAX     = 3'd6;

	// register index codes (byte address / 4)
	typedef enum logic [1:0] {
		REG_NOISE = 2'd0,
		REG_DELTA = 2'd1,
		REG_TILES = 2'd2,
		REG_BPT   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [NOISE_W-1:0] noise;
		logic [DELTA_W-1:0] delta;
		logic [TILES_W-1:0] tiles;
		logic [BPT_W-1:0]   bpt;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic div_start;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_end;
		logic div_done;
	} sts_t;

endpackage

// File: rtl/dct_lowfreq_frame_change_detector_top.sv
// ----------------------------------------------------------------------------
// dct_lowfreq_frame_change_detector_top
// Frame change detector on the four lowest DCT coefficients of each block.
// ----------------------------------------------------------------------------
// Each input transaction is one 8x8 block; the IDLE state accepts it and reads
// its row of four previous samples from the single-port 16384 x 64 bit sample
// store, and the READ state forms the differences and writes the new row back.
// After the last block of a frame, the ACC and SCALE states close the frame
// total and scale it by 2000, DIV runs the bit-serial division by the tile
// count, and EMIT loads the result register while it is free; the result
// register is held until taken, and a result still waiting stalls the load.
// Rows never written since reset read as zero through a fill mark, so no
// clearing pass runs after reset. Registers sit at byte addresses 0, 4, 8, 12:
// noise_threshold, delta_threshold, frame_tiles, blocks_per_tile.
module dct_lowfreq_frame_change_detector_top import dlfcd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [SAMP_W-1:0] coef_dc,
	input  logic signed [SAMP_W-1:0] coef_row0_col1,
	input  logic signed [SAMP_W-1:0] coef_row1_col0,
	input  logic signed [SAMP_W-1:0] coef_row1_col1,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     frame_changed,
	output logic [SCORE_W-1:0]       frame_score,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready
);

	logic [NOISE_W-1:0] noise_q;
	logic [DELTA_W-1:0] delta_q;
	logic [TILES_W-1:0] tiles_q;
	logic [BPT_W-1:0]   bpt_q;
	reg_idx_t           reg_idx;
	logic               wr_en;
	cfg_t               cfg;
	cmd_t               cmd;
	sts_t               sts;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q <= NOISE_RESET;
			delta_q <= DELTA_RESET;
			tiles_q <= TILES_RESET;
			bpt_q   <= BPT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NOISE: noise_q <= pwdata[NOISE_W-1:0];
				REG_DELTA: delta_q <= pwdata[DELTA_W-1:0];
				REG_TILES: tiles_q <= pwdata[TILES_W-1:0];
				REG_BPT:   bpt_q   <= pwdata[BPT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_NOISE: prdata = PDATA_W'(noise_q);
			REG_DELTA: prdata = PDATA_W'(delta_q);
			REG_TILES: prdata = PDATA_W'(tiles_q);
			REG_BPT:   prdata = PDATA_W'(bpt_q);
			default:   prdata = '0;
		endcase
	end

	assign cfg = '{noise: noise_q, delta: delta_q, tiles: tiles_q, bpt: bpt_q};

	dlfcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dlfcd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.coef_dc        (coef_dc),
		.coef_row0_col1 (coef_row0_col1),
		.coef_row1_col0 (coef_row1_col0),
		.coef_row1_col1 (coef_row1_col1),
		.sts            (sts),
		.frame_changed  (frame_changed),
		.frame_score    (frame_score)
	);

endmodule

// File: rtl/dlfcd_div.sv
// ----------------------------------------------------------------------------
// dlfcd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlfcd_div import dlfcd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [TILES_W-1:0]    divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [TILES_W-1:0]    rem_q;
	logic [TILES_W-1:0]    den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic [TILES_W:0]      trial;
	logic [TILES_W:0]      trial_sub;
	logic                  fits;

	// trial subtract of the shifted remainder
	always_comb begin
		trial     = {rem_q, quo_q[DIVIDEND_W-1]};
		fits      = trial >= {1'b0, den_q};
		trial_sub = trial - {1'b0, den_q};
	end

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? trial_sub[TILES_W-1:0] : trial[TILES_W-1:0];
		end
	end

	assign done     = busy_q && (cnt_q == CNT_W'(DIVIDEND_W - 1));
	assign quotient = quo_q;

endmodule

// File: rtl/dlfcd_dp.sv
// ----------------------------------------------------------------------------
// dlfcd_dp
// Datapath: 2x2 inverse DCT, sample store, block SAD, frame total, score.
// ----------------------------------------------------------------------------
`include "dct_lowfreq_frame_change_detector_top_assert.svh"

module dlfcd_dp import dlfcd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  cfg_t                     cfg,
	input  logic signed [SAMP_W-1:0] coef_dc,
	input  logic signed [SAMP_W-1:0] coef_row0_col1,
	input  logic signed [SAMP_W-1:0] coef_row1_col0,
	input  logic signed [SAMP_W-1:0] coef_row1_col1,
	output sts_t                     sts,
	output logic                     frame_changed,
	output logic [SCORE_W-1:0]       frame_score
);

	// halve toward zero and clamp to a signed sample
	function automatic logic [SAMP_W-1:0] half_sat(input logic signed [SAMP_W+1:0] s);
		logic signed [SAMP_W+1:0] adj;
		logic signed [SAMP_W:0]   h;
		adj = s + $signed({{(SAMP_W+1){1'b0}}, s[SAMP_W+1]});
		h   = adj[SAMP_W+1:1];
		if (h > $signed({2'b00, {(SAMP_W-1){1'b1}}})) begin
			h = $signed({2'b00, {(SAMP_W-1){1'b1}}});
		end else if (h < $signed({2'b11, {(SAMP_W-1){1'b0}}})) begin
			h = $signed({2'b11, {(SAMP_W-1){1'b0}}});
		end
		return h[SAMP_W-1:0];
	endfunction

	logic [ROW_W-1:0]  mem [MAX_BLOCKS];

	logic signed [SAMP_W:0]   bf_a, bf_b, bf_c, bf_d;
	logic signed [SAMP_W+1:0] raw0, raw1, raw2, raw3;
	logic [ROW_W-1:0]         row_new;
	logic [ROW_W-1:0]         row_s1;
	logic [ROW_W-1:0]         rd_q;
	logic                     hit_s1;
	logic [ROW_W-1:0]         old_row;
	logic signed [SAMP_W:0]   diff [SPB];
	logic [SAMP_W-1:0]        mag [SPB];
	logic [SUM_W-1:0]         blk_sum;
	logic [SUM_W-1:0]         sum_s2;
	logic                     pend_s2;

	logic [POS_W-1:0]      pos_q;
	logic [POS_W:0]        pos_next;
	logic [ADDR_W-1:0]     addr;
	logic [FILL_W-1:0]     addr_ext;
	logic [FILL_W-1:0]     fill_q;
	logic [TILES_W-1:0]    eff_tiles;
	logic [BPT_W-1:0]      eff_bpt;
	logic [LEN_W-1:0]      frame_len;
	logic [TOTAL_W-1:0]    total_q;
	logic [DIVIDEND_W-1:0] scaled;
	logic [DIVIDEND_W-1:0] quo;
	logic [SCORE_W-1:0]    score_sat;

	// butterfly for the four samples
	always_comb begin
		bf_a = {coef_dc[SAMP_W-1], coef_dc} + {coef_row0_col1[SAMP_W-1], coef_row0_col1};
		bf_b = {coef_dc[SAMP_W-1], coef_dc} - {coef_row0_col1[SAMP_W-1], coef_row0_col1};
		bf_c = {coef_row1_col0[SAMP_W-1], coef_row1_col0}
			+ {coef_row1_col1[SAMP_W-1], coef_row1_col1};
		bf_d = {coef_row1_col0[SAMP_W-1], coef_row1_col0}
			- {coef_row1_col1[SAMP_W-1], coef_row1_col1};
		raw0 = {bf_a[SAMP_W], bf_a} + {bf_c[SAMP_W], bf_c};
		raw1 = {bf_a[SAMP_W], bf_a} - {bf_c[SAMP_W], bf_c};
		raw2 = {bf_b[SAMP_W], bf_b} + {bf_d[SAMP_W], bf_d};
		raw3 = {bf_b[SAMP_W], bf_b} - {bf_d[SAMP_W], bf_d};
		row_new = {half_sat(raw3), half_sat(raw2), half_sat(raw1), half_sat(raw0)};
	end

	// frame geometry with clamped configuration
	always_comb begin
		eff_tiles = (cfg.tiles == '0) ? TILES_RESET : cfg.tiles;
		if (cfg.bpt < BPT_MIN) begin
			eff_bpt = BPT_MIN;
		end else if (cfg.bpt > BPT_MAX) begin
			eff_bpt = BPT_MAX;
		end else begin
			eff_bpt = cfg.bpt;
		end
		frame_len = {{(LEN_W-TILES_W){1'b0}}, eff_tiles}
			* {{(LEN_W-BPT_W){1'b0}}, eff_bpt};
		pos_next  = {1'b0, pos_q} + 1'b1;
		addr      = pos_q[ADDR_W-1:0];
		addr_ext  = {1'b0, addr};
	end

	assign sts.frame_end = pos_next >= {1'b0, frame_len};

	// absolute differences against the stored samples
	always_comb begin
		old_row = hit_s1 ? rd_q : '0;
		blk_sum = '0;
		for (int k = 0; k < SPB; k++) begin
			diff[k] = $signed({row_s1[k*SAMP_W+SAMP_W-1], row_s1[k*SAMP_W +: SAMP_W]})
				- $signed({old_row[k*SAMP_W+SAMP_W-1], old_row[k*SAMP_W +: SAMP_W]});
			mag[k]  = diff[k][SAMP_W] ? SAMP_W'(-diff[k]) : diff[k][SAMP_W-1:0];
			blk_sum = blk_sum + SUM_W'(mag[k]);
		end
	end

	// read the row on capture, write the new row back on update
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q <= mem[addr];
		end
		if (cmd.update) begin
			mem[addr] <= row_s1;
		end
	end

	// hold block payload between stages
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_s1 <= row_new;
			hit_s1 <= addr_ext < fill_q;
		end
		if (cmd.update) begin
			sum_s2 <= blk_sum;
		end
	end

	// advance position, fill mark and frame total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fill_q  <= '0;
			pend_s2 <= 1'b0;
			total_q <= '0;
		end else begin
			if (cmd.update) begin
				pos_q <= sts.frame_end ? '0 : pos_next[POS_W-1:0];
				if (addr_ext == fill_q) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			pend_s2 <= cmd.update;
			if (cmd.div_start) begin
				total_q <= '0;
			end else if (pend_s2 && (sum_s2 >= cfg.noise)) begin
				total_q <= total_q + TOTAL_W'(sum_s2);
			end
		end
	end

	// scale the total by 2000 with shifts
	assign scaled = (DIVIDEND_W'(total_q) << SCALE_SH_A)
		- (DIVIDEND_W'(total_q) << SCALE_SH_B)
		- (DIVIDEND_W'(total_q) << SCALE_SH_C);

	dlfcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (scaled),
		.divisor  (eff_tiles),
		.done     (sts.div_done),
		.quotient (quo)
	);

	// saturate the score and load the result register
	assign score_sat = (|quo[DIVIDEND_W-1:SCORE_W]) ? '1 : quo[SCORE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			frame_score   <= score_sat;
			frame_changed <= score_sat >= cfg.delta;
		end
	end

	`DLFCD_ASSERT(a_fill_covers_pos, clk, arst_n, (addr_ext <= fill_q), "position ahead of fill mark")
	`DLFCD_ASSERT(a_total_cleared, clk, arst_n, cmd.div_start |=> (total_q == '0), "total not cleared at frame end")

endmodule

// File: rtl/dlfcd_ctrl.sv
// ----------------------------------------------------------------------------
// dlfcd_ctrl
// Controller: block sequencing, frame end scoring and result handshake.
// ----------------------------------------------------------------------------
`include "dct_lowfreq_frame_change_detector_top_assert.svh"

module dlfcd_ctrl import dlfcd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_ACC   = 6'b000100,
		ST_SCALE = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// decode commands from the state
	always_comb begin
		in_ready      = state_q == ST_IDLE;
		cmd.capture   = in_valid && (state_q == ST_IDLE);
		cmd.update    = state_q == ST_READ;
		cmd.div_start = state_q == ST_SCALE;
		cmd.out_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = sts.frame_end ? ST_ACC : ST_IDLE;
			end
			ST_ACC: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`DLFCD_ASSERT(a_accept_to_read, clk, arst_n, (in_valid && in_ready) |=> (state_q == ST_READ), "accepted block did not enter READ")
	`DLFCD_NEVER(a_done_in_div, clk, arst_n, sts.div_done && (state_q != ST_DIV), "divider finished outside DIV")
	`DLFCD_ASSERT(a_result_from_emit, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_EMIT), "result raised outside EMIT")

endmodule
